/* rtl/core/gbm_pkg.sv */
`timescale 1ns / 1ps

package gbm_pkg;

    localparam int MAX_TARGETS_DEF = 32;
    localparam int COORD_W         = 21;
    localparam int SUM_W           = 48;
    localparam int TALLY_W         = 26;
    localparam int FRAME_W         = 16;
    localparam int CFG_W           = 16;
    localparam int TCNT_W          = 6;
    localparam int DIV_N_W         = 48;
    localparam int DIV_D_W         = 26;
    localparam int STEP_W          = 6;
    localparam int SNAP_STEPS      = 22;
    localparam int MEAN_STEPS      = 48;
    localparam int IN_DATA_W       = 72;
    localparam int OUT_DATA_W      = 72;
    localparam int OUT_FIELDS_W    = 69;
    localparam int ADDR_W          = 4;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

    localparam logic [1:0] REG_GRID = 2'd0;
    localparam logic [1:0] REG_MAXS = 2'd1;
    localparam logic [1:0] REG_TCNT = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_EOS   = 2'd2,
        CMD_FIN   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        DIV_X    = 2'd0,
        DIV_Y    = 2'd1,
        DIV_MEAN = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic [CFG_W-1:0]  grid;
        logic [CFG_W-1:0]  scan_cap;
        logic [TCNT_W-1:0] tcount;
    } t_cfg;

    typedef struct packed {
        logic     item_load;
        logic     div_start;
        t_div_sel div_sel;
        logic     latch_cx;
        logic     latch_cy;
        logic     cell_wr;
        logic     k_clr;
        logic     k_inc;
        logic     rd_cell;
        logic     acc_rd;
        logic     fin_rd;
        logic     acc_wr;
        logic     out_load;
        logic     clear_all;
        logic     frame_inc;
    } t_ctl;

    typedef struct packed {
        t_opcode cmd;
        logic    point_ok;
        logic    div_done;
        logic    k_last;
        logic    out_accept;
    } t_sts;

endpackage

/* rtl/core/gbm_divider.sv */
`timescale 1ns / 1ps

module gbm_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gbm_pkg::STEP_W-1:0]   i_steps,
    input  logic [gbm_pkg::DIV_N_W-1:0]  i_dividend,
    input  logic [gbm_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [gbm_pkg::DIV_N_W-1:0]  o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [gbm_pkg::STEP_W-1:0]  r_cnt;
    logic [gbm_pkg::DIV_N_W-1:0] r_q;
    logic [gbm_pkg::DIV_D_W-1:0] r_r;
    logic [gbm_pkg::DIV_D_W-1:0] r_d;
    logic [gbm_pkg::DIV_D_W:0]   shifted;
    logic [gbm_pkg::DIV_D_W:0]   trial;

    assign shifted = {r_r, r_q[gbm_pkg::DIV_N_W-1]};
    assign trial   = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == gbm_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            if (!trial[gbm_pkg::DIV_D_W]) begin
                r_r <= trial[gbm_pkg::DIV_D_W-1:0];
                r_q <= {r_q[gbm_pkg::DIV_N_W-2:0], 1'b1};
            end else begin
                r_r <= shifted[gbm_pkg::DIV_D_W-1:0];
                r_q <= {r_q[gbm_pkg::DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/core/gbm_datapath.sv */
`timescale 1ns / 1ps

module gbm_datapath #(
    parameter int MAX_TARGETS = gbm_pkg::MAX_TARGETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbm_pkg::t_cfg                   i_cfg,
    input  gbm_pkg::t_ctl                   i_ctl,
    input  logic [gbm_pkg::IN_DATA_W-1:0]   i_tdata,
    input  logic [1:0]                      i_tuser,
    input  logic                            i_m_tready,
    output gbm_pkg::t_sts                   o_sts,
    output logic                            o_m_tvalid,
    output logic [gbm_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int CW     = gbm_pkg::COORD_W;

    logic [1:0]                  r_cmd;
    logic [4:0]                  r_idx;
    logic signed [CW-1:0]        r_x;
    logic signed [CW-1:0]        r_y;
    logic signed [CW-1:0]        r_z;
    logic                        r_rv;
    logic [CW-1:0]               r_cx;
    logic [CW-1:0]               r_cy;
    gbm_pkg::t_div_sel           r_sel;
    logic [IDX_W-1:0]            r_k;
    logic [IDX_W-1:0]            r_best;
    logic [IDX_W-1:0]            r_rd_idx;
    logic                        r_rd_vld;
    logic                        r_hit;
    logic [2*CW-1:0]             r_cell_q;
    logic [gbm_pkg::SUM_W-1:0]   r_sum_q;
    logic [gbm_pkg::TALLY_W-1:0] r_tq;
    logic                        r_acc_v;
    logic                        r_sum_neg;
    logic [gbm_pkg::FRAME_W-1:0] r_frame;
    logic [MAX_TARGETS-1:0]      r_vld;
    logic                        r_o_valid;
    logic                        r_o_last;
    logic [gbm_pkg::OUT_FIELDS_W-1:0] r_o_data;

    logic [2*CW-1:0]             cell_mem [MAX_TARGETS];
    logic [gbm_pkg::SUM_W-1:0]   sum_mem  [MAX_TARGETS];
    logic [gbm_pkg::TALLY_W-1:0] tally_mem[MAX_TARGETS];

    logic [gbm_pkg::CFG_W-1:0]   g;
    logic [31:0]                 n_full;
    logic [CNT_W-1:0]            n_act;
    logic                        limit;
    logic [CW-1:0]               coord;
    logic [CW-1:0]               mag;
    logic [CW:0]                 num;
    logic [gbm_pkg::SUM_W-1:0]   sum_eff;
    logic [gbm_pkg::TALLY_W-1:0] tally_eff;
    logic [gbm_pkg::SUM_W-1:0]   sum_abs;
    logic [gbm_pkg::DIV_N_W-1:0] div_n;
    logic [gbm_pkg::DIV_D_W-1:0] div_d;
    logic [gbm_pkg::STEP_W-1:0]  div_steps;
    logic                        div_done;
    logic [gbm_pkg::DIV_N_W-1:0] quot;
    logic                        snap_neg;
    logic [CW-1:0]               snap_val;
    logic [CW-1:0]               mean_val;
    logic [IDX_W-1:0]            acc_addr;
    logic                        acc_rd_any;
    logic                        out_accept;
    logic [gbm_pkg::FRAME_W-1:0] frames;

    assign g      = (i_cfg.grid == '0) ? gbm_pkg::CFG_W'(1) : i_cfg.grid;
    assign n_full = (i_cfg.tcount == '0) ? 32'd1 :
                    ((32'(i_cfg.tcount) > 32'(MAX_TARGETS)) ? 32'(MAX_TARGETS) :
                     32'(i_cfg.tcount));
    assign n_act  = n_full[CNT_W-1:0];
    assign limit  = (i_cfg.scan_cap != '0) && (r_frame >= i_cfg.scan_cap);
    assign frames = ((i_cfg.scan_cap != '0) && (r_frame > i_cfg.scan_cap)) ?
                    i_cfg.scan_cap : r_frame;

    assign coord  = (i_ctl.div_sel == gbm_pkg::DIV_Y) ? r_y : r_x;
    assign mag    = coord[CW-1] ? (~coord + 1'b1) : coord;
    assign num    = {mag, 1'b0} + (CW+1)'(g);

    assign sum_eff   = r_acc_v ? r_sum_q : '0;
    assign tally_eff = r_acc_v ? r_tq : '0;
    assign sum_abs   = sum_eff[gbm_pkg::SUM_W-1] ? (~sum_eff + 1'b1) : sum_eff;

    always_comb begin
        if (i_ctl.div_sel == gbm_pkg::DIV_MEAN) begin
            div_n     = sum_abs;
            div_d     = tally_eff;
            div_steps = gbm_pkg::STEP_W'(gbm_pkg::MEAN_STEPS);
        end else begin
            div_n     = {num, (gbm_pkg::DIV_N_W-CW-1)'(0)};
            div_d     = {(gbm_pkg::DIV_D_W-gbm_pkg::CFG_W-1)'(0), g, 1'b0};
            div_steps = gbm_pkg::STEP_W'(gbm_pkg::SNAP_STEPS);
        end
    end

    gbm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_steps    (div_steps),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign snap_neg = (r_sel == gbm_pkg::DIV_Y) ? r_y[CW-1] : r_x[CW-1];
    assign snap_val = snap_neg ? (~quot[CW-1:0] + 1'b1) : quot[CW-1:0];
    assign mean_val = r_sum_neg ? (~quot[CW-1:0] + 1'b1) : quot[CW-1:0];

    assign acc_rd_any = i_ctl.acc_rd || i_ctl.fin_rd;
    assign acc_addr   = i_ctl.fin_rd ? r_k : r_best;
    assign out_accept = r_o_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.item_load) begin
            r_cmd <= i_tuser;
            r_idx <= i_tdata[4:0];
            r_x   <= i_tdata[25:5];
            r_y   <= i_tdata[46:26];
            r_z   <= i_tdata[67:47];
            r_rv  <= i_tdata[68];
        end
        if (i_ctl.div_start) begin
            r_sel <= i_ctl.div_sel;
        end
        if (i_ctl.latch_cx) begin
            r_cx <= snap_val;
        end
        if (i_ctl.latch_cy) begin
            r_cy <= snap_val;
        end
        if (i_ctl.cell_wr && (32'(r_idx) < 32'(MAX_TARGETS))) begin
            cell_mem[IDX_W'(r_idx)] <= {snap_val, r_cx};
        end
        if (i_ctl.rd_cell) begin
            r_cell_q <= cell_mem[r_k];
        end
        r_rd_idx <= r_k;
        if (acc_rd_any) begin
            r_sum_q <= sum_mem[acc_addr];
            r_tq    <= tally_mem[acc_addr];
            r_acc_v <= r_vld[acc_addr];
        end
        if (i_ctl.div_start) begin
            r_sum_neg <= sum_eff[gbm_pkg::SUM_W-1];
        end
        if (i_ctl.acc_wr && r_hit && (tally_eff != gbm_pkg::TALLY_MAX)) begin
            sum_mem[r_best]   <= sum_eff + gbm_pkg::SUM_W'(r_z);
            tally_mem[r_best] <= tally_eff + 1'b1;
        end
        if (i_ctl.out_load) begin
            r_o_data <= {frames, (tally_eff == '0),
                         tally_eff, ((tally_eff == '0) ? {CW{1'b0}} : mean_val), 5'(r_k)};
            r_o_last <= (CNT_W'(r_k) == n_act - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_best    <= '0;
            r_hit     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_frame   <= '0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.rd_cell;
            if (i_ctl.k_clr) begin
                r_k      <= '0;
                r_hit    <= 1'b0;
            end else if (i_ctl.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (r_rd_vld && (r_cell_q == {r_cy, r_cx})) begin
                r_hit  <= 1'b1;
                r_best <= r_rd_idx;
            end
            if (i_ctl.acc_wr && r_hit && (tally_eff != gbm_pkg::TALLY_MAX)) begin
                r_vld[r_best] <= 1'b1;
            end
            if (i_ctl.frame_inc && (r_frame != gbm_pkg::FRAME_MAX)) begin
                r_frame <= r_frame + 1'b1;
            end
            if (i_ctl.clear_all) begin
                r_vld   <= '0;
                r_frame <= '0;
            end
            if (i_ctl.out_load) begin
                r_o_valid <= 1'b1;
            end else if (out_accept) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cmd        = gbm_pkg::t_opcode'(r_cmd);
    assign o_sts.point_ok   = r_rv && !limit;
    assign o_sts.div_done   = div_done;
    assign o_sts.k_last     = (CNT_W'(r_k) == n_act - 1'b1);
    assign o_sts.out_accept = out_accept;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {(gbm_pkg::OUT_DATA_W-gbm_pkg::OUT_FIELDS_W)'(0), r_o_data};
    assign o_m_tlast  = r_o_last;

endmodule

/* rtl/core/gbm_ctrl.sv */
`timescale 1ns / 1ps

module gbm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gbm_pkg::t_sts  i_sts,
    output gbm_pkg::t_ctl  o_ctl,
    output logic           o_ready
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_SNAPX     = 12'b0000_0000_0100,
        S_SNAPY     = 12'b0000_0000_1000,
        S_SCAN      = 12'b0000_0001_0000,
        S_SCAN_WAIT = 12'b0000_0010_0000,
        S_ACC_RD    = 12'b0000_0100_0000,
        S_ACC_WR    = 12'b0000_1000_0000,
        S_FIN_RD    = 12'b0001_0000_0000,
        S_FIN_START = 12'b0010_0000_0000,
        S_FIN_DIV   = 12'b0100_0000_0000,
        S_FIN_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.item_load = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    gbm_pkg::CMD_LOAD: begin
                        o_ctl.div_start = 1'b1;
                        o_ctl.div_sel   = gbm_pkg::DIV_X;
                        n_state         = S_SNAPX;
                    end
                    gbm_pkg::CMD_POINT: begin
                        if (i_sts.point_ok) begin
                            o_ctl.div_start = 1'b1;
                            o_ctl.div_sel   = gbm_pkg::DIV_X;
                            n_state         = S_SNAPX;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    gbm_pkg::CMD_EOS: begin
                        o_ctl.frame_inc = 1'b1;
                        n_state         = S_IDLE;
                    end
                    default: begin
                        o_ctl.k_clr = 1'b1;
                        n_state     = S_FIN_RD;
                    end
                endcase
            end
            S_SNAPX: begin
                if (i_sts.div_done) begin
                    o_ctl.latch_cx  = 1'b1;
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_sel   = gbm_pkg::DIV_Y;
                    n_state         = S_SNAPY;
                end
            end
            S_SNAPY: begin
                o_ctl.div_sel = gbm_pkg::DIV_Y;
                if (i_sts.div_done) begin
                    o_ctl.latch_cy = 1'b1;
                    if (i_sts.cmd == gbm_pkg::CMD_LOAD) begin
                        o_ctl.cell_wr = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_ctl.k_clr = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_ctl.rd_cell = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_SCAN_WAIT;
                end else begin
                    o_ctl.k_inc = 1'b1;
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_ACC_RD;
            end
            S_ACC_RD: begin
                o_ctl.acc_rd = 1'b1;
                n_state      = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_ctl.acc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_FIN_RD: begin
                o_ctl.fin_rd = 1'b1;
                n_state      = S_FIN_START;
            end
            S_FIN_START: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel   = gbm_pkg::DIV_MEAN;
                n_state         = S_FIN_DIV;
            end
            S_FIN_DIV: begin
                o_ctl.div_sel = gbm_pkg::DIV_MEAN;
                if (i_sts.div_done) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_FIN_OUT;
                end
            end
            S_FIN_OUT: begin
                if (i_sts.out_accept) begin
                    if (i_sts.k_last) begin
                        o_ctl.clear_all = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_ctl.k_inc = 1'b1;
                        n_state     = S_FIN_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/grid_binned_target_height_mean_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Transfer condition          Contents
// s_axis    in         s_axis_tvalid & tready      load, point, end of scan, finish
// m_axis    out        m_axis_tvalid & tready      one result per active target
// apb       in         psel & penable & pwrite     grid size, scan cap, target slots
// Load items, and point items in range and under the scan cap, each take two snapping
// divisions of 22 steps each on the shared divider; a point then scans the target cells,
// one per cycle. Finish computes each result with a 48-step mean division and waits while
// the output stalls. Reset is synchronous and active low and clears sums, tallies and
// frames at once through per-slot valid bits.
// Input is not taken while a result waits on the output.

module grid_binned_target_height_mean_unit #(
    parameter int MAX_TARGETS = gbm_pkg::MAX_TARGETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // target_index[4:0], x_mm[25:5], y_mm[46:26], z_mm[67:47], range_valid[68]
    input  logic [gbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_index[4:0], mean_z_mm[25:5], samples[51:26], missing[52], frames[68:53]
    output logic [gbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbm_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    gbm_pkg::t_cfg r_cfg;
    gbm_pkg::t_ctl ctl;
    gbm_pkg::t_sts sts;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid     <= gbm_pkg::CFG_W'(20);
            r_cfg.scan_cap <= gbm_pkg::CFG_W'(5);
            r_cfg.tcount   <= gbm_pkg::TCNT_W'(1);
        end else if (wr) begin
            case (paddr[3:2])
                gbm_pkg::REG_GRID: r_cfg.grid     <= pwdata[15:0];
                gbm_pkg::REG_MAXS: r_cfg.scan_cap <= pwdata[15:0];
                gbm_pkg::REG_TCNT: r_cfg.tcount   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gbm_pkg::REG_GRID: prdata = {16'd0, r_cfg.grid};
            gbm_pkg::REG_MAXS: prdata = {16'd0, r_cfg.scan_cap};
            gbm_pkg::REG_TCNT: prdata = {26'd0, r_cfg.tcount};
            default:           prdata = '0;
        endcase
    end

    gbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_ready (s_axis_tready)
    );

    gbm_datapath #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ctl      (ctl),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_sts      (sts),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/core/gbm_checker.sv */
`timescale 1ns / 1ps

module gbm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transfer");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an input transfer");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("result after the final one");

endmodule

bind grid_binned_target_height_mean_unit gbm_checker u_gbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
